### rtl/fnc_pkg.sv
// fnc_pkg: shared constants, types and state encoding for the fat next cluster lookup
// no dependencies; compile first
package fnc_pkg;

  localparam int WINDOW_SECTORS = 4;
  localparam int SECTOR_BYTES   = 512;
  localparam int WIN_BYTES      = WINDOW_SECTORS * SECTOR_BYTES;

  localparam int CL_W   = 28;
  localparam int OFF_W  = CL_W + 2;
  localparam int SB_W   = $clog2(SECTOR_BYTES);
  localparam int SEC_W  = OFF_W - SB_W;
  localparam int WIN_AW = $clog2(WIN_BYTES);
  // window-relative offsets wrap at 32 bits, so a far entry reads as outside
  localparam int LOC_W  = 32;
  localparam int CNT_W  = 3;
  localparam int RSC_W  = 16;
  localparam int CFG_W  = 16;

  localparam logic [1:0] FMT_FAT12 = 2'd0;
  localparam logic [1:0] FMT_FAT16 = 2'd1;
  localparam logic [1:0] FMT_FAT32 = 2'd2;

  localparam logic       OP_LOOKUP = 1'b0;
  localparam logic       OP_FILL   = 1'b1;

  localparam logic       KIND_ANSWER  = 1'b0;
  localparam logic       KIND_REQUEST = 1'b1;

  localparam logic       REG_TABLE_FORMAT = 1'b0;
  localparam logic       REG_RESERVED     = 1'b1;

  localparam logic [11:0] FAT12_MASK = 12'h0FFF;
  localparam logic [11:0] EOC12      = 12'hFF8;
  localparam logic [15:0] EOC16      = 16'hFFF8;
  localparam logic [31:0] EOC32      = 32'h0FFF_FFF8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_DONE
  } fnc_state_t;

  typedef struct packed {
    logic fill_write;
    logic miss_load;
    logic read_start;
    logic use_pending;
    logic read_step;
    logic answer_load;
  } fnc_cmd_t;

  typedef struct packed {
    logic op;
    logic hit;
    logic fill_last;
    logic read_last;
    logic slot_free;
  } fnc_status_t;

endpackage

### rtl/fnc_if.sv
// fnc_if: valid/ready channel interfaces for lookup words and result words
// depends on fnc_pkg for field widths
interface fnc_lookup_if import fnc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [CL_W-1:0] cluster_number;
  logic [7:0]      fill_byte;

  modport source (output valid, op, cluster_number, fill_byte, input ready);
  modport sink   (input valid, op, cluster_number, fill_byte, output ready);
endinterface

interface fnc_result_if import fnc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] link_entry;
  logic        end_of_chain;
  logic [31:0] read_sector;
  logic [4:0]  read_sector_count;

  modport source (output valid, result_kind, link_entry, end_of_chain, read_sector,
                  read_sector_count, input ready);
  modport sink   (input valid, result_kind, link_entry, end_of_chain, read_sector,
                  read_sector_count, output ready);
endinterface

### rtl/fnc_ctrl.sv
// fnc_ctrl: controller state machine, sequences fill, window read and answer
// depends on fnc_pkg for state and command/status types
module fnc_ctrl import fnc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  fnc_status_t status,
  output fnc_cmd_t    cmd
);

  fnc_state_t state;
  fnc_state_t state_next;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && status.op == OP_LOOKUP) begin
          state_next = status.hit ? ST_READ : ST_FILL;
        end
      end
      ST_FILL: begin
        if (accept && status.op == OP_FILL && status.fill_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (status.read_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = status.slot_free;
        if (accept && status.op == OP_LOOKUP) begin
          cmd.read_start = status.hit;
          cmd.miss_load  = !status.hit;
        end
      end
      ST_FILL: begin
        in_ready = status.slot_free;
        if (accept && status.op == OP_FILL) begin
          cmd.fill_write  = 1'b1;
          cmd.read_start  = status.fill_last;
          cmd.use_pending = 1'b1;
        end
      end
      ST_READ: begin
        cmd.read_step = 1'b1;
      end
      ST_DONE: begin
        cmd.answer_load = status.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // a fill word dropped in idle never starts a read
  assert property (@(posedge clk) disable iff (rst)
    (accept && state == ST_IDLE && status.op == OP_FILL) |=> state == ST_IDLE)
    else $error("stray fill word left idle");

  // pending answer is only started by the last fill word
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && state_next == ST_READ) |-> (cmd.fill_write && status.fill_last))
    else $error("fill ended early");

  // read phase always ends in the answer state
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && status.read_last) |=> state == ST_DONE)
    else $error("read phase did not reach answer");

endmodule

### rtl/fnc_dpath.sv
// fnc_dpath: config registers, table window memory, hit test, entry assembly, result register
// depends on fnc_pkg and fnc_result_if
module fnc_dpath import fnc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              op,
  input  logic [CL_W-1:0]   cluster_number,
  input  logic [7:0]        fill_byte,
  input  fnc_cmd_t          cmd,
  output fnc_status_t       status,
  fnc_result_if.source      result
);

  logic [1:0]       table_format;
  logic [RSC_W-1:0] reserved_sector_count;

  logic [7:0]        mem [WIN_BYTES];
  logic              win_valid;
  logic [SEC_W-1:0]  win_first;
  logic [CL_W-1:0]   pending_cluster;
  logic [WIN_AW-1:0] fill_pos;

  logic [CL_W-1:0]   work_cluster;
  logic [LOC_W-1:0]  base;
  logic [CNT_W-1:0]  cnt;
  logic [31:0]       word;
  logic [7:0]        rd_data;
  logic              rd_ok;

  logic              out_valid;
  logic              slot_free;

  // offset and hit test on the selected cluster
  logic [CL_W-1:0]   sel_cluster;
  logic [OFF_W-1:0]  offset;
  logic [SEC_W-1:0]  sector;
  logic [SEC_W-1:0]  sec_diff;
  logic              in_win;
  logic [LOC_W-1:0]  local_off;
  logic [LOC_W-1:0]  local_end;
  logic [CNT_W-1:0]  n_bytes;
  logic [LOC_W-1:0]  rd_addr;
  logic              rd_en;
  logic [1:0]        byte_pos;

  logic [31:0]       ans_val;
  logic              ans_eoc;

  assign sel_cluster = cmd.use_pending ? pending_cluster : cluster_number;
  assign n_bytes     = (table_format == FMT_FAT12 || table_format == FMT_FAT16) ?
                       CNT_W'(2) : CNT_W'(4);

  always_comb begin
    case (table_format)
      FMT_FAT12: offset = OFF_W'(sel_cluster) + OFF_W'(sel_cluster[CL_W-1:1]);
      FMT_FAT16: offset = {1'b0, sel_cluster, 1'b0};
      default:   offset = {sel_cluster, 2'b00};
    endcase
  end

  assign sector    = offset[OFF_W-1:SB_W];
  assign sec_diff  = sector - win_first;
  assign in_win    = win_valid && (sector >= win_first) &&
                     (sec_diff < SEC_W'(WINDOW_SECTORS));
  assign local_off = LOC_W'(offset) - LOC_W'({win_first, {SB_W{1'b0}}});
  assign local_end = local_off + LOC_W'(n_bytes) - LOC_W'(1);

  assign slot_free = !out_valid || result.ready;

  assign status.op        = op;
  assign status.hit       = in_win && (local_end < LOC_W'(WIN_BYTES));
  assign status.fill_last = (fill_pos == WIN_AW'(WIN_BYTES - 1));
  assign status.read_last = (cnt == n_bytes);
  assign status.slot_free = slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_format          <= FMT_FAT12;
      reserved_sector_count <= RSC_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_FORMAT: table_format          <= cfg_data[1:0];
        REG_RESERVED:     reserved_sector_count <= cfg_data[RSC_W-1:0];
        default:          table_format          <= table_format;
      endcase
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
      fill_pos  <= '0;
    end else begin
      if (cmd.miss_load) begin
        win_valid <= 1'b1;
        fill_pos  <= '0;
      end else if (cmd.fill_write) begin
        fill_pos <= status.fill_last ? '0 : fill_pos + WIN_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.miss_load) begin
      win_first       <= sector;
      pending_cluster <= cluster_number;
    end
  end

  // window memory: one write port for fill, one registered read port
  assign rd_addr = base + LOC_W'(cnt);
  assign rd_en   = cmd.read_step && (cnt < n_bytes);

  always_ff @(posedge clk) begin
    if (cmd.fill_write) begin
      mem[fill_pos] <= fill_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr[WIN_AW-1:0]];
      rd_ok   <= rd_addr < LOC_W'(WIN_BYTES);
    end
  end

  // byte-serial entry assembly
  assign byte_pos = 2'(cnt - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.read_start) begin
      work_cluster <= sel_cluster;
      base         <= local_off;
      cnt          <= '0;
      word         <= '0;
    end else if (cmd.read_step) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt != '0) begin
        word[8*byte_pos +: 8] <= rd_ok ? rd_data : 8'h00;
      end
    end
  end

  always_comb begin
    case (table_format)
      FMT_FAT12: begin
        ans_val = work_cluster[0] ? 32'(word[15:4]) : 32'(word[11:0] & FAT12_MASK);
        ans_eoc = ans_val >= 32'(EOC12);
      end
      FMT_FAT16: begin
        ans_val = 32'(word[15:0]);
        ans_eoc = ans_val >= 32'(EOC16);
      end
      FMT_FAT32: begin
        ans_val = word;
        ans_eoc = ans_val >= EOC32;
      end
      default: begin
        ans_val = word;
        ans_eoc = 1'b1;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.miss_load || cmd.answer_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.miss_load) begin
      result.result_kind       <= KIND_REQUEST;
      result.link_entry        <= '0;
      result.end_of_chain      <= 1'b0;
      result.read_sector       <= 32'(reserved_sector_count) + 32'(sector);
      result.read_sector_count <= 5'(WINDOW_SECTORS);
    end else if (cmd.answer_load) begin
      result.result_kind       <= KIND_ANSWER;
      result.link_entry        <= ans_val;
      result.end_of_chain      <= ans_eoc;
      result.read_sector       <= '0;
      result.read_sector_count <= '0;
    end
  end

  assign result.valid = out_valid;

  // the result register is never overwritten while a word still waits
  assert property (@(posedge clk) disable iff (rst)
    (cmd.miss_load || cmd.answer_load) |-> slot_free)
    else $error("result register overwritten");

  // a miss always leaves a valid window starting at the missed sector
  assert property (@(posedge clk) disable iff (rst)
    cmd.miss_load |=> (win_valid && fill_pos == '0))
    else $error("window not moved on miss");

  // the pending answer only starts after the window is full
  assert property (@(posedge clk) disable iff (rst)
    (cmd.read_start && cmd.use_pending) |-> status.fill_last)
    else $error("pending answer before window full");

endmodule

### rtl/fat_next_cluster_lookup.sv
// fat_next_cluster_lookup: a hit passes the read state, then the answer state loads the
// answer once the result slot is free; miss: read request valid the cycle after accept;
// fill words taken one per cycle while the result slot is free, then read and answer as for
// a hit; one lookup at a time, the entry bytes come serially through the single read port
// reset: window invalid, table_format FAT12, reserved_sector_count 1; window memory not cleared
module fat_next_cluster_lookup import fnc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  fnc_lookup_if.sink       lookup,
  fnc_result_if.source     result
);

  fnc_cmd_t    cmd;
  fnc_status_t status;
  logic        in_ready;

  assign lookup.ready = in_ready;

  fnc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (lookup.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fnc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (lookup.op),
    .cluster_number (lookup.cluster_number),
    .fill_byte      (lookup.fill_byte),
    .cmd            (cmd),
    .status         (status),
    .result         (result)
  );

endmodule

### bench/fnc_chain_checker.sv
// fnc_chain_checker: follows the register, lookup and result ports of the fat next cluster
// lookup, keeps its own copy of the sector window and checks every result word
// depends on fnc_pkg and the channel interfaces in fnc_if
`timescale 1ns / 1ps

module fnc_chain_checker import fnc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  fnc_lookup_if            lookup,
  fnc_result_if            result,
  output int               failures,
  output int               outstanding,
  output int               answers_seen,
  output int               requests_seen,
  output int               eoc_seen
);

  localparam logic [31:0] WIN_NONE   = 32'hFFFF_FFFF;
  localparam int          SHOW_LIMIT = 30;

  typedef struct packed {
    logic        kind;
    logic [31:0] link_entry;
    logic        end_of_chain;
    logic [31:0] read_sector;
    logic [4:0]  read_sector_count;
  } chain_word_t;

  logic [7:0]  win_mem [WIN_BYTES];
  logic [31:0] win_first;
  logic [27:0] held_cluster;
  int unsigned fill_pos;
  logic        filling;
  logic [1:0]  fmt;
  logic [15:0] rsc;
  chain_word_t due_q[$];
  int          shown;

  function automatic logic [31:0] entry_addr(input logic [1:0] f, input logic [27:0] cl);
    logic [31:0] c;
    c = {4'd0, cl};
    case (f)
      FMT_FAT12: return (c * 3) >> 1;
      FMT_FAT16: return c * 2;
      default:   return c * 4;
    endcase
  endfunction

  // bytes past the window read as zero
  function automatic logic [31:0] win_byte(input logic [31:0] idx);
    return (idx < WIN_BYTES) ? {24'd0, win_mem[idx[WIN_AW-1:0]]} : 32'd0;
  endfunction

  function automatic logic window_holds(input logic [31:0] off);
    logic [31:0] sec;
    logic [31:0] rel;
    logic [31:0] span;
    sec  = off / SECTOR_BYTES;
    rel  = off - win_first * SECTOR_BYTES;
    span = (fmt <= FMT_FAT16) ? 32'd2 : 32'd4;
    if (win_first == WIN_NONE || sec < win_first) return 1'b0;
    if (sec - win_first >= WINDOW_SECTORS) return 1'b0;
    return (rel + span - 1) < WIN_BYTES;
  endfunction

  function automatic chain_word_t chain_answer(input logic [27:0] cl);
    chain_word_t w;
    logic [31:0] rel;
    logic [31:0] pair;
    logic [31:0] val;
    rel  = entry_addr(fmt, cl) - win_first * SECTOR_BYTES;
    pair = win_byte(rel) | (win_byte(rel + 1) << 8);
    w = '0;
    w.kind = KIND_ANSWER;
    case (fmt)
      FMT_FAT12: begin
        val = cl[0] ? (pair >> 4) : (pair & {20'd0, FAT12_MASK});
        w.end_of_chain = (val >= {20'd0, EOC12});
      end
      FMT_FAT16: begin
        val = pair;
        w.end_of_chain = (val >= {16'd0, EOC16});
      end
      default: begin
        // raw 32-bit compare; the fourth format always flags end of chain
        val = pair | (win_byte(rel + 2) << 16) | (win_byte(rel + 3) << 24);
        w.end_of_chain = (fmt == FMT_FAT32) ? (val >= EOC32) : 1'b1;
      end
    endcase
    w.link_entry = val;
    return w;
  endfunction

  task automatic flag_field(input string what, input logic [31:0] want, input logic [31:0] seen);
    failures++;
    if (shown < SHOW_LIMIT)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
    shown++;
  endtask

  always @(posedge clk) begin
    chain_word_t w;
    chain_word_t got;
    logic [31:0] off;
    if (rst) begin
      win_first = WIN_NONE;
      held_cluster = '0;
      fill_pos = 0;
      filling = 1'b0;
      fmt = FMT_FAT12;
      rsc = 16'd1;
      due_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TABLE_FORMAT) fmt = cfg_data[1:0];
        else rsc = cfg_data[RSC_W-1:0];
      end

      if (lookup.valid && lookup.ready) begin
        if (lookup.op == OP_FILL) begin
          if (filling) begin
            win_mem[fill_pos[WIN_AW-1:0]] = lookup.fill_byte;
            fill_pos++;
            if (fill_pos == WIN_BYTES) begin
              filling = 1'b0;
              fill_pos = 0;
              due_q.push_back(chain_answer(held_cluster));
            end
          end
        end else if (!filling) begin
          off = entry_addr(fmt, lookup.cluster_number);
          if (window_holds(off)) begin
            due_q.push_back(chain_answer(lookup.cluster_number));
          end else begin
            win_first = off / SECTOR_BYTES;
            held_cluster = lookup.cluster_number;
            fill_pos = 0;
            filling = 1'b1;
            w = '0;
            w.kind = KIND_REQUEST;
            w.read_sector = {16'd0, rsc} + win_first;
            w.read_sector_count = 5'(WINDOW_SECTORS);
            due_q.push_back(w);
          end
        end
      end

      if (result.valid && result.ready) begin
        got.kind = result.result_kind;
        got.link_entry = result.link_entry;
        got.end_of_chain = result.end_of_chain;
        got.read_sector = result.read_sector;
        got.read_sector_count = result.read_sector_count;
        if (due_q.size() == 0) begin
          failures++;
          if (shown < SHOW_LIMIT)
            $display("%0t: result word with none expected, got kind %0d next %0h sector %0h",
                     $time, got.kind, got.link_entry, got.read_sector);
          shown++;
        end else begin
          w = due_q.pop_front();
          if (w.kind == KIND_ANSWER) begin
            answers_seen++;
            if (w.end_of_chain) eoc_seen++;
          end else begin
            requests_seen++;
          end
          if (got.kind !== w.kind) flag_field("result_kind", 32'(w.kind), 32'(got.kind));
          if (got.link_entry !== w.link_entry)
            flag_field("link_entry", w.link_entry, got.link_entry);
          if (got.end_of_chain !== w.end_of_chain)
            flag_field("end_of_chain", 32'(w.end_of_chain), 32'(got.end_of_chain));
          if (got.read_sector !== w.read_sector)
            flag_field("read_sector", w.read_sector, got.read_sector);
          if (got.read_sector_count !== w.read_sector_count)
            flag_field("read_sector_count", 32'(w.read_sector_count),
                       32'(got.read_sector_count));
        end
      end

      outstanding <= due_q.size();
    end
  end

endmodule

### bench/tb_fat_next_cluster_lookup.sv
// tb_fat_next_cluster_lookup: drives lookups, window fills and register writes into the
// fat next cluster lookup, with bursty input and a stalling result sink
// depends on fnc_pkg, fnc_if, the block itself and fnc_chain_checker
`timescale 1ns / 1ps

module tb_fat_next_cluster_lookup;
  import fnc_pkg::*;

  localparam logic [1:0]  FMT_ALL_EOC     = 2'd3;
  localparam logic [27:0] CL_MAX          = 28'hFFF_FFFF;
  localparam int          LOOKUP_TARGET   = 1950;
  localparam int          DRAIN_SLACK     = 16;
  localparam int          PRESSURE_AT     = 400;
  localparam int          PRESSURE_CYCLES = 300;
  localparam logic [7:0]  MARK [8] = '{8'hF7, 8'hFF, 8'hFF, 8'h0F, 8'hF8, 8'hFF, 8'hFF, 8'h0F};

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  fnc_lookup_if lookup ();
  fnc_result_if result ();

  int failures;
  int outstanding;
  int answers_seen;
  int requests_seen;
  int eoc_seen;

  // stimulus-side view of the window, only used to aim lookups at hits or misses
  logic [1:0]  cur_fmt;
  logic [31:0] cur_win;
  logic        win_ok;
  int          gap_left;
  int          burst_left;
  logic        quiet;
  int          lookups_sent;
  int          fills_sent;
  int          noise_sent;

  always #2 clk = ~clk;

  fat_next_cluster_lookup u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .lookup   (lookup),
    .result   (result)
  );

  fnc_chain_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .lookup       (lookup),
    .result       (result),
    .failures     (failures),
    .outstanding  (outstanding),
    .answers_seen (answers_seen),
    .requests_seen(requests_seen),
    .eoc_seen     (eoc_seen)
  );

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result sink: random stall odds that change now and then, plus one long hold-off
  initial begin : result_sink
    int   taken;
    int   hold_left;
    int   stall_odds;
    int   odds_left;
    logic pressed;
    taken = 0;
    hold_left = 0;
    stall_odds = 0;
    odds_left = 0;
    pressed = 1'b0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result.valid && result.ready) taken++;
      if (rst) begin
        result.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (!pressed && taken >= PRESSURE_AT) begin
        pressed = 1'b1;
        hold_left = PRESSURE_CYCLES;
        result.ready <= 1'b0;
      end else begin
        if (odds_left == 0) begin
          stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          odds_left = $urandom_range(16, 128);
        end
        odds_left--;
        result.ready <= ($urandom_range(1, 8) > stall_odds);
      end
    end
  end

  function automatic logic [31:0] entry_pos(input logic [1:0] f, input logic [27:0] cl);
    logic [31:0] c;
    c = {4'd0, cl};
    case (f)
      FMT_FAT12: return (c * 3) >> 1;
      FMT_FAT16: return c * 2;
      default:   return c * 4;
    endcase
  endfunction

  // range of clusters whose whole entry sits in the window starting at sector sec
  function automatic void hit_span(input logic [1:0] f, input logic [31:0] sec,
                                   output logic [31:0] lo, output logic [31:0] hi);
    longint unsigned b;
    longint unsigned l;
    longint unsigned h;
    b = longint'(sec) * SECTOR_BYTES;
    case (f)
      FMT_FAT12: begin
        l = (2 * b + 2) / 3;
        h = (2 * b + 2 * WIN_BYTES - 3) / 3;
      end
      FMT_FAT16: begin
        l = b / 2;
        h = (b + WIN_BYTES - 2) / 2;
      end
      default: begin
        l = b / 4;
        h = (b + WIN_BYTES - 4) / 4;
      end
    endcase
    if (h > CL_MAX) h = 64'(CL_MAX);
    if (l > CL_MAX) l = 64'(CL_MAX) + 64'd1;
    lo = 32'(l);
    hi = 32'(h);
  endfunction

  function automatic logic [7:0] fill_value(input int idx);
    int pick;
    pick = $urandom_range(0, 7);
    if (idx < 8) return MARK[idx];
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'h0F;
    if (pick == 2) return 8'hF7;
    if (pick == 3) return 8'hF8;
    if (pick <= 5) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_word(input logic op, input logic [27:0] cl, input logic [7:0] fb);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap_left = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    if (gap_left != 0) begin
      lookup.valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    burst_left--;
    lookup.valid <= 1'b1;
    lookup.op <= op;
    lookup.cluster_number <= cl;
    lookup.fill_byte <= fb;
    @(posedge clk);
    while (!lookup.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    lookup.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] f, input logic [15:0] r);
    cfg_we <= 1'b1;
    cfg_index <= REG_TABLE_FORMAT;
    cfg_data <= {{(CFG_W-2){1'b0}}, f};
    @(posedge clk);
    cfg_index <= REG_RESERVED;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_fmt = f;
  endtask

  task automatic fill_window();
    for (int i = 0; i < WIN_BYTES; i++) begin
      // a lookup now and then while the fill is open is dropped by the block
      if ($urandom_range(0, 511) == 0) begin
        send_word(OP_LOOKUP, 28'($urandom), 8'($urandom));
        noise_sent++;
      end
      send_word(OP_FILL, 28'($urandom), fill_value(i));
      fills_sent++;
    end
  endtask

  task automatic look_up(input logic [27:0] cl, output logic missed);
    logic [31:0] lo;
    logic [31:0] hi;
    hit_span(cur_fmt, cur_win, lo, hi);
    missed = !(win_ok && cl >= lo && cl <= hi);
    if (missed) begin
      cur_win = entry_pos(cur_fmt, cl) / SECTOR_BYTES;
      win_ok = 1'b1;
    end
    lookups_sent++;
    send_word(OP_LOOKUP, cl, 8'($urandom));
  endtask

  task automatic probe(input logic [27:0] cl);
    logic missed;
    look_up(cl, missed);
    if (missed) fill_window();
  endtask

  initial begin : stimulus
    logic        missed;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [27:0] cl;
    logic [1:0]  f;
    logic [15:0] r;
    int          n;
    int          sel;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TABLE_FORMAT;
    cfg_data = '0;
    lookup.valid = 1'b0;
    lookup.op = OP_LOOKUP;
    lookup.cluster_number = '0;
    lookup.fill_byte = '0;
    cur_fmt = FMT_FAT12;
    cur_win = '0;
    win_ok = 1'b0;
    gap_left = 0;
    burst_left = 0;
    quiet = 1'b0;
    lookups_sent = 0;
    fills_sent = 0;
    noise_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: fat12, one reserved sector
    send_word(OP_FILL, '0, 8'hA5);
    noise_sent++;
    probe(28'd0);
    probe(28'd0);
    probe(28'd1);
    probe(28'd1364);
    // entry whose second byte falls past the window end
    look_up(28'd1365, missed);
    send_word(OP_LOOKUP, CL_MAX, 8'h00);
    noise_sent++;
    if (missed) fill_window();
    probe(28'd1365);

    wait_drained();
    set_config(FMT_FAT16, 16'd0);
    probe(CL_MAX);
    probe(CL_MAX);
    probe(28'hFFF_FF00);
    probe(28'hFFF_FF01);
    probe(28'hFFF_FF02);

    wait_drained();
    set_config(FMT_FAT32, 16'hFFFF);
    look_up(CL_MAX, missed);
    // format switched while the fill is still open
    wait_drained();
    set_config(FMT_ALL_EOC, 16'hFFFF);
    if (missed) fill_window();
    probe(28'hFFF_FF80);
    probe(28'hFFF_FF81);
    wait_drained();
    set_config(FMT_FAT32, 16'hFFFF);
    probe(28'hFFF_FF80);
    probe(28'hFFF_FF81);
    probe(CL_MAX);

    while (lookups_sent < LOOKUP_TARGET) begin
      wait_drained();
      f = ($urandom_range(0, 7) == 0) ? FMT_ALL_EOC : 2'($urandom_range(0, 2));
      sel = $urandom_range(0, 3);
      r = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom);
      set_config(f, r);
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 160);
      repeat (n) begin
        hit_span(cur_fmt, cur_win, lo, hi);
        if (!win_ok || lo > hi || $urandom_range(0, 59) == 0) begin
          sel = $urandom_range(0, 3);
          if (sel <= 1) cl = 28'($urandom);
          else if (sel == 2 && lo != 0 && lo <= CL_MAX) cl = 28'(lo - 32'd1);
          else if (hi < CL_MAX) cl = 28'(hi + 32'd1);
          else cl = 28'($urandom);
        end else begin
          sel = $urandom_range(0, 9);
          if (sel == 0) cl = 28'(lo);
          else if (sel == 1) cl = 28'(hi);
          else cl = 28'(lo + $urandom_range(0, hi - lo));
        end
        probe(cl);
        if ($urandom_range(0, 31) == 0) begin
          send_word(OP_FILL, 28'($urandom), 8'($urandom));
          noise_sent++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_SLACK) @(posedge clk);
    $display("covered %0d lookups and %0d fill words (%0d dropped words) over all four formats",
             lookups_sent, fills_sent, noise_sent);
    $display("checked %0d answers (%0d end of chain) and %0d read requests",
             answers_seen, eoc_seen, requests_seen);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
